// ===== design/vector3_arith_unit_core_defines.svh =====
// ---------------------------------------------------------------------------
// Vector ALU assertion macros
// Shared property templates for the vector arithmetic unit checks.
// ---------------------------------------------------------------------------
`ifndef VECTOR3_ARITH_UNIT_CORE_DEFINES_SVH
`define VECTOR3_ARITH_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define V3A_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define V3A_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/v3alu_pkg.sv =====
// ---------------------------------------------------------------------------
// Vector ALU package
// Widths, operation codes and shared types of the vector arithmetic unit.
// ---------------------------------------------------------------------------
package v3alu_pkg;

  // Operand width; operands are taken from the low bits of each field.
  localparam int COMP_WIDTH = 16;
  localparam int CW         = COMP_WIDTH;
  localparam int FIELD_W    = 16;
  localparam int RES_W      = 33;
  localparam int OP_W       = 3;

  // Derived arithmetic widths.
  localparam int PROD_W     = 2 * CW;
  localparam int SUM_W      = CW + 1;
  localparam int SQ_W       = 2 * CW;
  localparam int RAD_W      = SQ_W + 16;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int NORM_SHIFT = 24;
  localparam int MAG_W      = CW + 1;
  localparam int NUM_W      = MAG_W + NORM_SHIFT;
  // The normalized magnitude never exceeds 1.0 in Q16.16.
  localparam int Q_W        = 17;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_SCALE = 3'd2,
    OP_MULT  = 3'd3,
    OP_DOT   = 3'd4,
    OP_CROSS = 3'd5,
    OP_LEN   = 3'd6,
    OP_NORM  = 3'd7
  } op_t;

  // What one lane finds in its first stage.
  typedef struct packed {
    logic signed [PROD_W-1:0] m1;
    logic signed [PROD_W-1:0] m2;
    logic signed [SUM_W-1:0]  sum;
  } lane_res_t;

  // Sideband carried alongside the root and divide pipelines.
  typedef struct packed {
    op_t                        op;
    logic [2:0][CW-1:0]         a;
    logic [2:0][RES_W-1:0]      vec;
    logic [RES_W-1:0]           scalar;
  } sb_t;

endpackage

// ===== design/v3alu_ifs.sv =====
// ---------------------------------------------------------------------------
// Vector ALU channels
// Valid/ready channels for the operand beats and the result beats.
// ---------------------------------------------------------------------------
interface v3alu_in_if import v3alu_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic signed [FIELD_W-1:0] a_x;
  logic signed [FIELD_W-1:0] a_y;
  logic signed [FIELD_W-1:0] a_z;
  logic signed [FIELD_W-1:0] b_x;
  logic signed [FIELD_W-1:0] b_y;
  logic signed [FIELD_W-1:0] b_z;
  logic signed [FIELD_W-1:0] scale_factor;

  modport source (output valid, operation, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor,
                  input ready);
  modport sink   (input valid, operation, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor,
                  output ready);
endinterface

interface v3alu_out_if import v3alu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] res_x;
  logic signed [RES_W-1:0] res_y;
  logic signed [RES_W-1:0] res_z;
  logic signed [RES_W-1:0] res_scalar;
  logic                    zero_vector;

  modport source (output valid, res_x, res_y, res_z, res_scalar, zero_vector,
                  input ready);
  modport sink   (input valid, res_x, res_y, res_z, res_scalar, zero_vector,
                  output ready);
endinterface

// ===== design/v3alu_lane.sv =====
// ---------------------------------------------------------------------------
// Vector ALU lane
// Per-component front stage: one sum and two products, registered.
// ---------------------------------------------------------------------------
module v3alu_lane import v3alu_pkg::*; (
  input  logic                 clk,
  input  logic                 adv,
  input  op_t                  op,
  input  logic signed [CW-1:0] a_self,
  input  logic signed [CW-1:0] b_self,
  input  logic signed [CW-1:0] a_j,
  input  logic signed [CW-1:0] a_k,
  input  logic signed [CW-1:0] b_j,
  input  logic signed [CW-1:0] b_k,
  input  logic signed [CW-1:0] s,
  output lane_res_t            res
);

  logic signed [CW-1:0] opa;
  logic signed [CW-1:0] opb;
  lane_res_t            res_nxt;
  lane_res_t            res_r;

  // Pick the operands of the main multiplier for this operation.
  always_comb begin
    case (op)
      OP_SCALE: begin
        opa = a_self;
        opb = s;
      end
      OP_MULT, OP_DOT: begin
        opa = a_self;
        opb = b_self;
      end
      OP_CROSS: begin
        opa = a_j;
        opb = b_k;
      end
      default: begin
        opa = a_self;
        opb = a_self;
      end
    endcase
  end

  // Main product, second cross term and the add or subtract.
  always_comb begin
    res_nxt.m1  = PROD_W'(opa) * PROD_W'(opb);
    res_nxt.m2  = PROD_W'(a_k) * PROD_W'(b_j);
    res_nxt.sum = (op == OP_SUB) ? SUM_W'(a_self) - SUM_W'(b_self)
                                 : SUM_W'(a_self) + SUM_W'(b_self);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== design/v3alu_sqrt.sv =====
// ---------------------------------------------------------------------------
// Vector ALU square root
// Pipelined restoring square root, one result bit per stage.
// ---------------------------------------------------------------------------
module v3alu_sqrt import v3alu_pkg::*; (
  input  logic              clk,
  input  logic              adv,
  input  logic [SQ_W-1:0]   sq_sum,
  output logic [ROOT_W-1:0] root
);

  localparam int REM_W = ROOT_W + 2;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sq_stage_t;

  sq_stage_t st_r   [ROOT_W];
  sq_stage_t st_nxt [ROOT_W];
  sq_stage_t st_in;

  // One digit: bring down two radicand bits and try to subtract 4*root+1.
  function automatic sq_stage_t sq_step(sq_stage_t cur);
    logic [REM_W+1:0] sh;
    logic [REM_W+1:0] trial;
    logic             ge;
    sq_stage_t        nxt;
    sh       = {cur.rem, cur.rad[RAD_W-1 -: 2]};
    trial    = (REM_W+2)'({cur.root, 2'b01});
    ge       = (sh >= trial);
    nxt.rem  = ge ? REM_W'(sh - trial) : REM_W'(sh);
    nxt.root = {cur.root[ROOT_W-2:0], ge};
    nxt.rad  = cur.rad << 2;
    return nxt;
  endfunction

  // Radicand is the sum of squares scaled by 2^16.
  always_comb begin
    st_in.rem  = '0;
    st_in.root = '0;
    st_in.rad  = {sq_sum, 16'b0};
  end

  always_comb begin
    st_nxt[0] = sq_step(st_in);
    for (int k = 1; k < ROOT_W; k++) begin
      st_nxt[k] = sq_step(st_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < ROOT_W; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign root = st_r[ROOT_W-1].root;

endmodule

// ===== design/v3alu_div.sv =====
// ---------------------------------------------------------------------------
// Vector ALU divider
// Pipelined restoring divide of one component by the length, one bit a stage.
// ---------------------------------------------------------------------------
module v3alu_div import v3alu_pkg::*; (
  input  logic                    clk,
  input  logic                    adv,
  input  logic signed [CW-1:0]    a_in,
  input  logic [ROOT_W-1:0]       den,
  output logic signed [RES_W-1:0] quo
);

  typedef struct packed {
    logic [ROOT_W-1:0] rem;
    logic [Q_W-1:0]    num;
    logic [Q_W-1:0]    q;
    logic [ROOT_W-1:0] den;
    logic              neg;
  } dv_stage_t;

  dv_stage_t        st_r   [Q_W];
  dv_stage_t        st_nxt [Q_W];
  dv_stage_t        st_in;
  logic [MAG_W-1:0] mag;
  logic [NUM_W-1:0] numer;
  logic [RES_W-1:0] q_ext;

  // One quotient bit: shift in a numerator bit and try to subtract.
  function automatic dv_stage_t dv_step(dv_stage_t cur);
    logic [ROOT_W:0] sh;
    logic            ge;
    dv_stage_t       nxt;
    sh      = {cur.rem, cur.num[Q_W-1]};
    ge      = (sh >= {1'b0, cur.den});
    nxt     = cur;
    nxt.rem = ge ? ROOT_W'(sh - {1'b0, cur.den}) : ROOT_W'(sh);
    nxt.num = cur.num << 1;
    nxt.q   = {cur.q[Q_W-2:0], ge};
    return nxt;
  endfunction

  // Magnitude times 2^24; the high part is already below the length.
  always_comb begin
    mag       = a_in[CW-1] ? MAG_W'(-MAG_W'(a_in)) : MAG_W'(a_in);
    numer     = {mag, NORM_SHIFT'(0)};
    st_in.rem = ROOT_W'(numer[NUM_W-1:Q_W]);
    st_in.num = numer[Q_W-1:0];
    st_in.q   = '0;
    st_in.den = den;
    st_in.neg = a_in[CW-1];
  end

  always_comb begin
    st_nxt[0] = dv_step(st_in);
    for (int k = 1; k < Q_W; k++) begin
      st_nxt[k] = dv_step(st_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < Q_W; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  // Truncation toward zero: restore the sign on the magnitude.
  assign q_ext = RES_W'(st_r[Q_W-1].q);
  assign quo   = st_r[Q_W-1].neg ? $signed(-q_ext) : $signed(q_ext);

endmodule

// ===== design/vector3_arith_unit_core.sv =====
// A taken operand beat goes through the lane registers, the root and divide pipelines and the output register.
// Throughput: one beat per cycle while no result is blocked at the output; the 24-stage root and 17-stage divide
// pipelines each retire one beat per cycle.
// The output register holds a waiting result while bubbles keep moving.
// Reset (rst_n low, synchronous) clears all valid flags; data is not reset.
// ---------------------------------------------------------------------------
// Vector ALU core
// Three lanes for the components, a merge stage, a pipelined square root
// and three pipelined dividers behind it.
// ---------------------------------------------------------------------------
`include "vector3_arith_unit_core_defines.svh"

module vector3_arith_unit_core import v3alu_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  v3alu_in_if.sink  in_bus,
  v3alu_out_if.source out_bus
);

  localparam int LINE = ROOT_W + Q_W;

  logic                    adv;
  logic signed [CW-1:0]    a_in [3];
  logic signed [CW-1:0]    b_in [3];
  logic signed [CW-1:0]    s_in;
  op_t                     op_in;
  lane_res_t               lane_q [3];

  logic                    v1_r;
  op_t                     op1_r;
  logic [2:0][CW-1:0]      a1_r;
  logic [LINE-1:0]         vl_r;
  sb_t                     sb_r [LINE];
  sb_t                     sb_nxt;
  logic [SQ_W-1:0]         sq_sum;
  logic [ROOT_W-1:0]       root;
  logic [ROOT_W-1:0]       len_r [Q_W];
  logic signed [RES_W-1:0] quo [3];

  logic                    out_valid_r;
  logic [RES_W-1:0]        out_x_r, out_y_r, out_z_r, out_s_r;
  logic                    out_zero_r;
  logic [2:0][RES_W-1:0]   fin_vec;
  logic [RES_W-1:0]        fin_scalar;
  logic                    fin_zero;
  sb_t                     sb_last;
  logic [ROOT_W-1:0]       len_last;

  // The pipeline moves unless a result waits and another is due behind it.
  assign adv          = !vl_r[LINE-1] || !out_valid_r || out_bus.ready;
  assign in_bus.ready = adv;

  // Operands from the low bits of each field.
  assign op_in   = op_t'(in_bus.operation);
  assign a_in[0] = $signed(in_bus.a_x[CW-1:0]);
  assign a_in[1] = $signed(in_bus.a_y[CW-1:0]);
  assign a_in[2] = $signed(in_bus.a_z[CW-1:0]);
  assign b_in[0] = $signed(in_bus.b_x[CW-1:0]);
  assign b_in[1] = $signed(in_bus.b_y[CW-1:0]);
  assign b_in[2] = $signed(in_bus.b_z[CW-1:0]);
  assign s_in    = $signed(in_bus.scale_factor[CW-1:0]);

  // Component lanes; lane i forms the cross term from the other two axes.
  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3alu_lane u_lane (
      .clk    (clk),
      .adv    (adv),
      .op     (op_in),
      .a_self (a_in[i]),
      .b_self (b_in[i]),
      .a_j    (a_in[(i + 1) % 3]),
      .a_k    (a_in[(i + 2) % 3]),
      .b_j    (b_in[(i + 1) % 3]),
      .b_k    (b_in[(i + 2) % 3]),
      .s      (s_in),
      .res    (lane_q[i])
    );
  end

  // Merge stage: per-component results, dot product and sum of squares.
  always_comb begin
    sb_nxt.op     = op1_r;
    sb_nxt.a      = a1_r;
    sb_nxt.scalar = '0;
    for (int i = 0; i < 3; i++) begin
      case (op1_r)
        OP_ADD, OP_SUB:    sb_nxt.vec[i] = RES_W'(lane_q[i].sum) <<< 8;
        OP_SCALE, OP_MULT: sb_nxt.vec[i] = RES_W'(lane_q[i].m1);
        OP_CROSS:          sb_nxt.vec[i] = RES_W'(lane_q[i].m1) - RES_W'(lane_q[i].m2);
        default:           sb_nxt.vec[i] = '0;
      endcase
    end
    if (op1_r == OP_DOT) begin
      sb_nxt.scalar = RES_W'(lane_q[0].m1) + RES_W'(lane_q[1].m1) + RES_W'(lane_q[2].m1);
    end
    sq_sum = SQ_W'($unsigned(lane_q[0].m1)) + SQ_W'($unsigned(lane_q[1].m1)) +
             SQ_W'($unsigned(lane_q[2].m1));
  end

  v3alu_sqrt u_sqrt (
    .clk    (clk),
    .adv    (adv),
    .sq_sum (sq_sum),
    .root   (root)
  );

  // One divider per component, fed when the root is complete.
  for (genvar i = 0; i < 3; i++) begin : g_div
    v3alu_div u_div (
      .clk  (clk),
      .adv  (adv),
      .a_in ($signed(sb_r[ROOT_W-1].a[i])),
      .den  (root),
      .quo  (quo[i])
    );
  end

  // Valid flags and the output register state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      vl_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        v1_r <= in_bus.valid;
        vl_r <= {vl_r[LINE-2:0], v1_r};
      end
      if (adv && vl_r[LINE-1]) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Sideband and length delay lines.
  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r    <= op_in;
      a1_r     <= {a_in[2], a_in[1], a_in[0]};
      sb_r[0]  <= sb_nxt;
      for (int k = 1; k < LINE; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
      len_r[0] <= root;
      for (int k = 1; k < Q_W; k++) begin
        len_r[k] <= len_r[k-1];
      end
    end
  end

  // Final selection for length and normalize.
  assign sb_last  = sb_r[LINE-1];
  assign len_last = len_r[Q_W-1];

  always_comb begin
    fin_vec    = sb_last.vec;
    fin_scalar = sb_last.scalar;
    fin_zero   = 1'b0;
    case (sb_last.op)
      OP_LEN: begin
        fin_scalar = RES_W'(len_last);
      end
      OP_NORM: begin
        if (len_last == '0) begin
          fin_zero = 1'b1;
          fin_vec  = '0;
        end else begin
          for (int i = 0; i < 3; i++) begin
            fin_vec[i] = quo[i];
          end
        end
      end
      default: begin
        fin_zero = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv && vl_r[LINE-1]) begin
      out_x_r    <= fin_vec[0];
      out_y_r    <= fin_vec[1];
      out_z_r    <= fin_vec[2];
      out_s_r    <= fin_scalar;
      out_zero_r <= fin_zero;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.res_x       = $signed(out_x_r);
  assign out_bus.res_y       = $signed(out_y_r);
  assign out_bus.res_z       = $signed(out_z_r);
  assign out_bus.res_scalar  = $signed(out_s_r);
  assign out_bus.zero_vector = out_zero_r;

  // Checks on the pipeline control and the zero-vector result.
  `V3A_ASSERT_SAME(a_zero_clean, out_valid_r && out_zero_r, out_x_r == '0 && out_y_r == '0 && out_z_r == '0 && out_s_r == '0, "zero vector beat carries nonzero data")
  `V3A_ASSERT_SAME(a_stall_cause, !adv, out_valid_r && !out_bus.ready && vl_r[LINE-1], "pipeline stalled without a blocked result")
  `V3A_ASSERT_NEXT(a_out_load, adv && vl_r[LINE-1], out_valid_r, "finished beat not presented")

endmodule
